// ----- rtl/ftsp_pkg.sv -----
package ftsp_pkg;

    // Defaults and fixed widths
    localparam int WORD_MAX_DEF = 32;
    localparam int SEG_LEN_W    = 9;   // holds a segment length up to 256
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = 2;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int ITEMS_W      = 9;
    localparam int CHAR_W       = 7;

    localparam logic [ITEMS_W-1:0] ITEM_CAP_RST = 9'd256;

    // Token codes
    localparam logic [4:0] TOK_START    = 5'd31;
    localparam logic [4:0] TOK_END      = 5'd30;
    localparam logic [4:0] TOK_RECORD   = 5'd28;
    localparam logic [4:0] TOK_POS_LAST = 5'd9;
    localparam logic [4:0] TOK_NEG_1ST  = 5'd17;
    localparam logic [4:0] TOK_NEG_LAST = 5'd25;
    localparam logic [4:0] TOK_NEG_BASE = 5'd16;
    localparam logic [4:0] TOK_ALPHA_LAST = 5'd25;
    localparam logic [4:0] TOK_MAP_A    = 5'd26;
    localparam logic [4:0] TOK_MAP_B    = 5'd27;
    localparam logic [4:0] PUNCT_CNT    = 5'd28;

    // Characters
    localparam logic [CHAR_W-1:0] CH_QMARK = 7'h3F;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 7'h41;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 7'h61;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_AT    = 7'h40;
    localparam logic [CHAR_W-1:0] CH_DASH  = 7'h2D;

    localparam logic [CHAR_W-1:0] PUNCT_MAP [28] = '{
        7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26, 7'h27, 7'h28, 7'h29, 7'h2A,
        7'h2B, 7'h2C, 7'h2F, 7'h3A, 7'h3B, 7'h3C, 7'h3D, 7'h3E, 7'h3F, 7'h5B,
        7'h5C, 7'h5D, 7'h5E, 7'h5F, 7'h60, 7'h7B, 7'h7C, 7'h7D
    };

    typedef enum logic [1:0] {
        M_NUM   = 2'd0,
        M_WORD  = 2'd1,
        M_SPEC  = 2'd2,
        M_SPEC2 = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        K_NUMBER = 2'd0,
        K_CHAR   = 2'd1,
        K_EMPTY  = 2'd2
    } t_kind;

    // Commands from the front to the back
    typedef enum logic [1:0] {
        C_CHAR   = 2'd0,
        C_NUMBER = 2'd1,
        C_EMPTY  = 2'd2,
        C_WORD   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_READ = 2'd1,
        B_EMIT = 2'd2
    } t_back_state;

    typedef struct packed {
        logic [4:0] token;
        logic       record_end;
    } t_in_item;

    typedef struct packed {
        t_kind              kind;
        logic signed [63:0] number_value;
        logic [CHAR_W-1:0]  char_code;
        logic               item_last;
    } t_out_item;

    // len: buffer slot for a character, segment length for a word
    typedef struct packed {
        t_op                  op;
        logic [63:0]          value;
        logic [CHAR_W-1:0]    chr;
        logic [SEG_LEN_W-1:0] len;
    } t_cmd;

    function automatic logic [CHAR_W-1:0] map_char(input t_mode m, input logic [4:0] t);
        logic [CHAR_W-1:0] c;
        c = CH_QMARK;
        unique case (m)
            M_SPEC2: begin
                if (t < PUNCT_CNT) c = PUNCT_MAP[t];
            end
            M_WORD: begin
                if (t <= TOK_ALPHA_LAST) c = CH_UP_A + {2'b00, t};
                else if (t == TOK_MAP_A) c = CH_SPACE;
                else if (t == TOK_MAP_B) c = CH_DOT;
            end
            M_SPEC: begin
                if (t <= TOK_ALPHA_LAST) c = CH_LO_A + {2'b00, t};
                else if (t == TOK_MAP_A) c = CH_AT;
                else if (t == TOK_MAP_B) c = CH_DASH;
            end
            default: c = CH_QMARK;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/five_bit_token_stream_parser_top.sv -----
// A number or empty-word result passes through the command queue and the output register
// when the back end is free; a word's first character follows its closing token through the
// queue and the B_READ and B_EMIT states. Throughput: one token per cycle into a 4-entry
// command queue while it is not full; the back end reads then emits each word character.
// Reset (i_rst_n low, synchronous): number mode, empty queue and output, item cap 256.
module five_bit_token_stream_parser_top
    import ftsp_pkg::*;
#(
    parameter int WORD_MAX = WORD_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_item              i_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_item             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [ITEMS_W-1:0] r_item_cap;
    logic               q_push, q_full, q_empty, q_pop;
    t_cmd               q_in, q_out;

    // Register file: item cap at word 0
    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1] == 1'b0) ?
                    {{(APB_DATA_W-ITEMS_W){1'b0}}, r_item_cap} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_cap <= ITEM_CAP_RST;
        end else if (psel && penable && pwrite && pready && !paddr[APB_ADDR_W-1]) begin
            r_item_cap <= pwdata[ITEMS_W-1:0];
        end
    end

    ftsp_front #(.WORD_MAX(WORD_MAX)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in        (i_in),
        .i_item_cap  (r_item_cap),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_cmd       (q_in)
    );

    ftsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_cmd   (q_out)
    );

    ftsp_back #(.WORD_MAX(WORD_MAX)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_cmd   (q_out),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

endmodule

// ----- rtl/ftsp_front.sv -----
module ftsp_front
    import ftsp_pkg::*;
#(
    parameter int WORD_MAX = WORD_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_in_item           i_in,
    input  logic [ITEMS_W-1:0] i_item_cap,
    input  logic               i_full,
    output logic               o_push,
    output t_cmd               o_cmd
);

    localparam int LEN_W = $clog2(WORD_MAX + 1);

    t_mode              r_mode, n_mode;
    logic [63:0]        r_acc, n_acc;
    logic               r_have, n_have;
    logic [LEN_W-1:0]   r_seg_len, n_seg_len;
    logic [ITEMS_W-1:0] r_items, n_items;

    logic        accept;
    logic [4:0]  tok;
    logic        is_start, is_end, is_rec, is_ctrl, is_pos, is_neg, closes, can_emit;
    logic [4:0]  neg_mag;
    logic [63:0] dext, acc_mul, acc_upd;
    logic        have_upd;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    // Token classification
    assign tok      = i_in.token;
    assign is_start = (tok == TOK_START);
    assign is_end   = (tok == TOK_END);
    assign is_rec   = (tok == TOK_RECORD);
    assign is_ctrl  = is_start || is_end || is_rec;
    assign is_pos   = (tok <= TOK_POS_LAST);
    assign is_neg   = (tok >= TOK_NEG_1ST) && (tok <= TOK_NEG_LAST);
    assign closes   = is_end || is_rec || (is_start && (r_mode != M_SPEC2));
    assign can_emit = (r_items < i_item_cap);

    // acc*10 + digit, negative digits subtract
    assign neg_mag = tok - TOK_NEG_BASE;
    assign dext    = is_pos ? {59'd0, tok} : (64'd0 - {59'd0, neg_mag});
    assign acc_mul = (r_acc << 3) + (r_acc << 1) + dext;
    assign acc_upd = (is_pos || is_neg) ? acc_mul : r_acc;
    assign have_upd = r_have || is_pos || is_neg;

    // Mode tracking and command generation
    always_comb begin
        n_mode    = r_mode;
        n_acc     = r_acc;
        n_have    = r_have;
        n_seg_len = r_seg_len;
        n_items   = r_items;
        o_push    = 1'b0;
        o_cmd     = '{op: C_CHAR, value: '0, chr: '0, len: '0};
        if (accept) begin
            if (r_mode == M_NUM) begin
                n_acc  = acc_upd;
                n_have = have_upd;
                if (is_start) n_mode = M_WORD;
                if (have_upd && (is_ctrl || i_in.record_end)) begin
                    if (can_emit) begin
                        o_push    = 1'b1;
                        o_cmd.op  = C_NUMBER;
                        o_cmd.value = acc_upd;
                        n_items   = r_items + 1'b1;
                    end
                    n_acc  = '0;
                    n_have = 1'b0;
                end
            end else if (closes) begin
                if (can_emit) begin
                    o_push    = 1'b1;
                    o_cmd.op  = (r_seg_len == '0) ? C_EMPTY : C_WORD;
                    o_cmd.len = SEG_LEN_W'(r_seg_len);
                    n_items   = r_items + 1'b1;
                end
                n_seg_len = '0;
                priority if (is_rec) begin
                    n_mode = M_NUM;
                end else if (is_end) begin
                    unique case (r_mode)
                        M_SPEC2: n_mode = M_SPEC;
                        M_SPEC:  n_mode = M_WORD;
                        default: n_mode = M_NUM;
                    endcase
                end else begin
                    n_mode = (r_mode == M_WORD) ? M_SPEC : M_SPEC2;
                end
            end else if (r_seg_len < LEN_W'(WORD_MAX)) begin
                o_push    = 1'b1;
                o_cmd.op  = C_CHAR;
                o_cmd.chr = map_char(r_mode, tok);
                o_cmd.len = SEG_LEN_W'(r_seg_len);
                n_seg_len = r_seg_len + 1'b1;
            end
            // record end: everything back to the reset values
            if (i_in.record_end) begin
                n_mode    = M_NUM;
                n_acc     = '0;
                n_have    = 1'b0;
                n_seg_len = '0;
                n_items   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_NUM;
            r_acc     <= '0;
            r_have    <= 1'b0;
            r_seg_len <= '0;
            r_items   <= '0;
        end else begin
            r_mode    <= n_mode;
            r_acc     <= n_acc;
            r_have    <= n_have;
            r_seg_len <= n_seg_len;
            r_items   <= n_items;
        end
    end

    a_rec_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.record_end) |=> (r_mode == M_NUM) && (r_items == '0) && !r_have)
        else $error("record end did not clear parser state");

    a_seg_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg_len <= LEN_W'(WORD_MAX))
        else $error("segment length beyond buffer size");

endmodule

// ----- rtl/ftsp_queue.sv -----
module ftsp_queue
    import ftsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (Q_PTR_W+1)'(i_push) - (Q_PTR_W+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> !o_full)
        else $error("command queue overflow");

endmodule

// ----- rtl/ftsp_back.sv -----
module ftsp_back
    import ftsp_pkg::*;
#(
    parameter int WORD_MAX = WORD_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_out
);

    localparam int IDX_W = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;

    logic [CHAR_W-1:0] r_chars [WORD_MAX];
    logic [CHAR_W-1:0] r_rd;

    t_back_state      r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_last_idx, n_last_idx;
    logic             r_out_valid;
    t_out_item        r_out;

    logic      out_free, wr_en, rd_en, load;
    t_out_item ld_item;

    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_out    = r_out;

    // Sequencer: store characters, emit numbers, drain words
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_last_idx = r_last_idx;
        o_pop      = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        load       = 1'b0;
        ld_item    = '{kind: K_CHAR, number_value: '0, char_code: '0, item_last: 1'b0};
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    unique case (i_cmd.op)
                        C_CHAR: begin
                            o_pop = 1'b1;
                            wr_en = 1'b1;
                        end
                        C_NUMBER: begin
                            if (out_free) begin
                                o_pop = 1'b1;
                                load  = 1'b1;
                                ld_item.kind         = K_NUMBER;
                                ld_item.number_value = $signed(i_cmd.value);
                                ld_item.item_last    = 1'b1;
                            end
                        end
                        C_EMPTY: begin
                            if (out_free) begin
                                o_pop = 1'b1;
                                load  = 1'b1;
                                ld_item.kind      = K_EMPTY;
                                ld_item.item_last = 1'b1;
                            end
                        end
                        C_WORD: begin
                            o_pop      = 1'b1;
                            n_idx      = '0;
                            n_last_idx = IDX_W'(i_cmd.len - 1'b1);
                            n_state    = B_READ;
                        end
                    endcase
                end
            end
            B_READ: begin
                rd_en   = 1'b1;
                n_state = B_EMIT;
            end
            B_EMIT: begin
                if (out_free) begin
                    load = 1'b1;
                    ld_item.kind      = K_CHAR;
                    ld_item.char_code = r_rd;
                    ld_item.item_last = (r_idx == r_last_idx);
                    if (r_idx == r_last_idx) begin
                        n_state = B_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = B_READ;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Character buffer
    always_ff @(posedge i_clk) begin
        if (wr_en) r_chars[i_cmd.len[IDX_W-1:0]] <= i_cmd.chr;
        if (rd_en) r_rd <= r_chars[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_IDLE;
            r_idx      <= '0;
            r_last_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_last_idx <= n_last_idx;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_out <= ld_item;
    end

    a_drain_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EMIT) |-> (r_idx <= r_last_idx))
        else $error("drain index past segment end");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("pop from empty command queue");

endmodule
